/* hdl/utf8sd_pkg.sv */
package utf8sd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 3;

  localparam logic [CP_W-1:0] ERR_CP_RESET = 21'd65533;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00d800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00dfff;

  // lead byte classes
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hf0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [BYTE_W-1:0] BITS2_MASK = 8'h1f;
  localparam logic [BYTE_W-1:0] BITS3_MASK = 8'h0f;
  localparam logic [BYTE_W-1:0] BITS4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] BITS_CONT  = 8'h3f;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // results of one input word: a run of error results, then an optional tail result
  typedef struct packed {
    logic [LEN_W-1:0] err_left;
    logic             tail_valid;
    logic [CP_W-1:0]  tail_cp;
    logic [LEN_W-1:0] tail_len;
  } job_t;

endpackage

/* hdl/utf8_stream_decoder.sv */
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+----------------------------------------
// in       | input     | in_valid / in_ready   | data_byte, end_of_buffer
// out      | output    | out_valid / out_ready | codepoint, is_error, byte_count, last_of_run
// cfg      | input     | cfg_write (no wait)   | cfg_data -> error code point
//
// A byte is decoded in the cycle it is accepted and its results land in one job register.
// A byte giving at most one result does not hold the input: one byte per cycle while out_ready is high.
// A byte giving k results (k up to 4) holds the input while the job register drains.
// in_ready is high when the job register is empty or its last result is taken this cycle.
// rst (synchronous) closes any open sequence, empties the job register, reloads U+FFFD.
module utf8_stream_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [utf8sd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                           end_of_buffer,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]    codepoint,
  output logic                           is_error,
  output logic [utf8sd_pkg::LEN_W-1:0]   byte_count,
  output logic                           last_of_run,
  input  logic                           cfg_write,
  input  logic [utf8sd_pkg::CP_W-1:0]    cfg_data
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0]  err_cp;
  logic [LEN_W-1:0] expected_length, expected_length_next;
  logic [LEN_W-1:0] received_count, received_count_next;
  logic [CP_W-1:0]  partial_cp, partial_cp_next;
  job_t             job, job_next;
  logic             job_valid;

  logic             in_fire, out_fire;
  logic             seq_open, byte_cont;
  logic [LEN_W-1:0] rc_inc;
  logic [CP_W-1:0]  cp_cat;
  logic             cp_surr;
  logic             lead_ascii, lead_multi;
  logic [LEN_W-1:0] lead_len;
  logic [CP_W-1:0]  lead_bits;

  // handshakes
  assign out_valid = job_valid;
  assign in_ready  = !job_valid || (out_ready && last_of_run);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // result fields from the job register
  assign is_error    = (job.err_left != LEN_NONE);
  assign codepoint   = is_error ? err_cp : job.tail_cp;
  assign byte_count  = is_error ? LEN_ONE : job.tail_len;
  assign last_of_run = is_error ? ((job.err_left == LEN_ONE) && !job.tail_valid) : 1'b1;

  // sequence state and byte classes
  assign seq_open  = (expected_length >= LEN_TWO) && (expected_length <= LEN_FOUR) &&
                     (received_count >= LEN_ONE) && (received_count < expected_length);
  assign byte_cont = ((data_byte & CONT_MASK) == CONT_CODE);
  assign rc_inc    = received_count + LEN_ONE;
  assign cp_cat    = {partial_cp[CP_W-7:0], data_byte[5:0] & BITS_CONT[5:0]};
  assign cp_surr   = (cp_cat >= SURR_LO) && (cp_cat <= SURR_HI);

  // lead decode
  always_comb begin
    lead_ascii = !data_byte[BYTE_W-1];
    lead_multi = 1'b1;
    lead_len   = LEN_ONE;
    lead_bits  = '0;
    if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
      lead_len  = 3'd2;
      lead_bits = CP_W'(data_byte & BITS2_MASK);
    end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
      lead_len  = 3'd3;
      lead_bits = CP_W'(data_byte & BITS3_MASK);
    end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
      lead_len  = LEN_FOUR;
      lead_bits = CP_W'(data_byte & BITS4_MASK);
    end else begin
      lead_multi = 1'b0;
    end
  end

  // decode one word into a job and the next sequence state
  always_comb begin
    logic do_lead;
    do_lead              = 1'b0;
    job_next             = '0;
    job_next.tail_cp     = cp_cat;
    job_next.tail_len    = LEN_ONE;
    expected_length_next = LEN_NONE;
    received_count_next  = LEN_NONE;
    partial_cp_next      = '0;
    if (!seq_open) begin
      do_lead = 1'b1;
    end else if (byte_cont) begin
      if (rc_inc == expected_length) begin
        if (cp_surr) begin
          job_next.err_left = expected_length;
        end else begin
          job_next.tail_valid = 1'b1;
          job_next.tail_len   = expected_length;
        end
      end else if (end_of_buffer) begin
        job_next.err_left = rc_inc;
      end else begin
        expected_length_next = expected_length;
        received_count_next  = rc_inc;
        partial_cp_next      = cp_cat;
      end
    end else begin
      job_next.err_left = received_count;
      do_lead           = 1'b1;
    end
    // the byte as a new lead
    if (do_lead) begin
      if (lead_ascii) begin
        job_next.tail_valid = 1'b1;
        job_next.tail_cp    = CP_W'(data_byte);
        job_next.tail_len   = LEN_ONE;
      end else if (!lead_multi || end_of_buffer) begin
        job_next.err_left = job_next.err_left + LEN_ONE;
      end else begin
        expected_length_next = lead_len;
        received_count_next  = LEN_ONE;
        partial_cp_next      = lead_bits;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      err_cp <= ERR_CP_RESET;
    end else if (cfg_write) begin
      err_cp <= cfg_data;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= LEN_NONE;
      received_count  <= LEN_NONE;
      partial_cp      <= '0;
    end else if (in_fire) begin
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      partial_cp      <= partial_cp_next;
    end
  end

  // job register: load on accept, count down on each result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid       <= 1'b0;
      job.err_left    <= LEN_NONE;
      job.tail_valid  <= 1'b0;
    end else if (in_fire) begin
      job_valid <= (job_next.err_left != LEN_NONE) || job_next.tail_valid;
      job       <= job_next;
    end else if (out_fire) begin
      if (last_of_run) begin
        job_valid <= 1'b0;
      end
      if (is_error) begin
        job.err_left <= job.err_left - LEN_ONE;
      end else begin
        job.tail_valid <= 1'b0;
      end
    end
  end

  // checks
  a_job_not_empty: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> ((job.err_left != LEN_NONE) || job.tail_valid))
    else $error("job register holds no result");

  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.err_left <= LEN_FOUR))
    else $error("more than four error results queued");

  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (expected_length != LEN_NONE) |->
      ((received_count >= LEN_ONE) && (received_count < expected_length)))
    else $error("sequence state out of range");

  a_eob_closes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_buffer) |=> (expected_length == LEN_NONE))
    else $error("sequence left open after end of buffer");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import utf8sd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;

  // one decoded result as it leaves the block
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic             err;
    logic [LEN_W-1:0] len;
    logic             last;
  } cp_result_t;

  // decoder state mirror plus queue of codepoints still owed by the block
  class codepoint_scoreboard;
    logic [CP_W-1:0]  error_cp;
    logic [LEN_W-1:0] seq_len;
    logic [LEN_W-1:0] seq_got;
    logic [CP_W-1:0]  seq_bits;
    cp_result_t       pending_codepoints[$];
    cp_result_t       step_results[$];
    int               mismatch_count;

    function new();
      error_cp = ERR_CP_RESET;
      mismatch_count = 0;
      close_sequence();
    endfunction

    function void close_sequence();
      seq_len = LEN_NONE;
      seq_got = LEN_NONE;
      seq_bits = '0;
    endfunction

    function void add_result(logic [CP_W-1:0] cp, logic err, logic [LEN_W-1:0] len);
      cp_result_t r;
      r.cp = cp;
      r.err = err;
      r.len = len;
      r.last = 1'b0;
      step_results.push_back(r);
    endfunction

    function void add_errors(logic [LEN_W-1:0] n);
      for (int i = 0; i < n; i++) add_result(error_cp, 1'b1, LEN_ONE);
    endfunction

    // a byte seen with no sequence open
    function void open_lead(logic [BYTE_W-1:0] b, logic eob);
      logic [LEN_W-1:0]  n;
      logic [BYTE_W-1:0] bits;
      if (b[7] == 1'b0) begin
        add_result({{(CP_W-BYTE_W){1'b0}}, b}, 1'b0, LEN_ONE);
        return;
      end
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        n = LEN_TWO;
        bits = b & BITS2_MASK;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        n = LEN_THREE;
        bits = b & BITS3_MASK;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        n = LEN_FOUR;
        bits = b & BITS4_MASK;
      end else begin
        add_errors(LEN_ONE);
        return;
      end
      if (eob) begin
        // multi-byte lead cut off by end of buffer
        close_sequence();
        add_errors(LEN_ONE);
      end else begin
        seq_len = n;
        seq_got = LEN_ONE;
        seq_bits = {{(CP_W-BYTE_W){1'b0}}, bits};
      end
    endfunction

    // predict the results of one accepted word
    function void decode_word(logic [BYTE_W-1:0] b, logic eob);
      logic [BYTE_W-1:0] payload;
      logic [CP_W-1:0]   cp;
      logic [LEN_W-1:0]  n;
      step_results.delete();
      if (seq_len < LEN_TWO || seq_len > LEN_FOUR || seq_got < LEN_ONE || seq_got >= seq_len)
      begin
        close_sequence();
        open_lead(b, eob);
      end else if ((b & CONT_MASK) == CONT_CODE) begin
        payload = b & BITS_CONT;
        seq_bits = {seq_bits[CP_W-7:0], payload[5:0]};
        seq_got = seq_got + 1'b1;
        if (seq_got == seq_len) begin
          cp = seq_bits;
          n = seq_len;
          close_sequence();
          // surrogate range is rejected byte by byte
          if (cp >= SURR_LO && cp <= SURR_HI) add_errors(n);
          else add_result(cp, 1'b0, n);
        end else if (eob) begin
          // continuation truncated by end of buffer
          n = seq_got;
          close_sequence();
          add_errors(n);
        end
      end else begin
        // sequence broken: flush taken bytes, then re-examine this one as a lead
        n = seq_got;
        close_sequence();
        add_errors(n);
        open_lead(b, eob);
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) pending_codepoints.push_back(step_results[i]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    // compare one taken result against the oldest prediction
    task check_codepoint(logic [CP_W-1:0] cp, logic err, logic [LEN_W-1:0] len, logic last);
      cp_result_t want;
      if (pending_codepoints.size() == 0) begin
        report($sformatf("unexpected result cp=%h err=%b len=%0d last=%b", cp, err, len, last));
        return;
      end
      want = pending_codepoints.pop_front();
      if (cp !== want.cp) report($sformatf("codepoint %h, expected %h", cp, want.cp));
      if (err !== want.err) report($sformatf("is_error %b, expected %b", err, want.err));
      if (len !== want.len) report($sformatf("byte_count %0d, expected %0d", len, want.len));
      if (last !== want.last) report($sformatf("last_of_run %b, expected %b", last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              end_of_buffer = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   codepoint;
  logic              is_error;
  logic [LEN_W-1:0]  byte_count;
  logic              last_of_run;
  logic              cfg_write = 1'b0;
  logic [CP_W-1:0]   cfg_data = '0;
  logic              hold_req = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int words_sent = 0;
  int cycle_count = 0;

  codepoint_scoreboard sb = new();

  utf8_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .codepoint    (codepoint),
    .is_error     (is_error),
    .byte_count   (byte_count),
    .last_of_run  (last_of_run),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: check taken results, then pick next ready, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_codepoint(codepoint, is_error, byte_count, last_of_run);
    if (hold_req) hold_left = 80;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(logic [BYTE_W-1:0] b, logic eob);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.decode_word(b, eob);
    words_sent++;
  endtask

  // write the error code point once the block has drained
  task automatic write_error_codepoint(logic [CP_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending_codepoints.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.error_cp = v;
  endtask

  // mostly well-formed sequences with random payload, some cut short, some noise
  task automatic send_random_sequence();
    logic [BYTE_W-1:0] seq[$];
    logic [BYTE_W-1:0] r;
    int pick, len, keep, eob_pct;
    pick = $urandom_range(0, 99);
    len = (pick < 8) ? 3 : $urandom_range(1, 4);
    r = BYTE_W'($urandom);
    eob_pct = 12;
    if (pick >= 85) begin
      seq.push_back(r);
      eob_pct = 20;
    end else begin
      case (len)
        1: seq.push_back({1'b0, r[6:0]});
        2: seq.push_back({3'b110, r[4:0]});
        3: seq.push_back(pick < 8 ? 8'hed : {4'b1110, r[3:0]});
        default: seq.push_back({5'b11110, r[2:0]});
      endcase
      for (int i = 1; i < len; i++) begin
        r = BYTE_W'($urandom);
        // lead ED with A0..BF lands in the surrogate range
        seq.push_back((pick < 8 && i == 1) ? {3'b101, r[4:0]} : {2'b10, r[5:0]});
      end
      if (pick >= 65 && len > 1) begin
        keep = $urandom_range(1, len - 1);
        while (seq.size() > keep) void'(seq.pop_back());
        eob_pct = 40;
      end
    end
    foreach (seq[i])
      send_word(seq[i], (i == seq.size() - 1) && ($urandom_range(0, 99) < eob_pct));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 21;
    rx_idle_pct = 55;

    // directed: ascii extremes, longest forms, then each error path
    send_word(8'h00, 1'b0);
    send_word(8'h7f, 1'b1);
    send_word(8'hc2, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hdf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hef, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hf7, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hbf, 1'b0);
    // stray continuation, bad lead
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    // non-continuation inside a 4-byte sequence
    send_word(8'hf0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h41, 1'b0);
    // truncation on the lead and on a continuation
    send_word(8'he0, 1'b1);
    send_word(8'hf0, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b1);
    // surrogate
    send_word(8'hed, 1'b0);
    send_word(8'ha0, 1'b0);
    send_word(8'h80, 1'b0);

    // valid code point equal to the error code point
    write_error_codepoint(21'h000041);
    send_word(8'h41, 1'b0);
    send_word(8'hf8, 1'b0);

    write_error_codepoint(21'h1fffff);
    while (words_sent < 175) send_random_sequence();

    tx_idle_pct = 55;
    rx_idle_pct = 21;
    write_error_codepoint('0);
    while (words_sent < 330) send_random_sequence();

    // no idling, with one long receiver hold-off to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_error_codepoint(CP_W'($urandom));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    while (words_sent < 470) send_random_sequence();

    // drain
    in_valid <= 1'b0;
    while (sb.pending_codepoints.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
